[rtl/pfc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants of the Playfair bigram cipher.
package pfc_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned LETTER_W = 8;
  localparam int unsigned DIM_W    = 4;
  localparam int unsigned ROW_W    = 6;
  localparam int unsigned COL_W    = 3;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;

  // Register values after reset.
  localparam logic                RST_DECODE_MODE = 1'b0;
  localparam logic [DIM_W-1:0]    RST_ROW_COUNT   = 4'd5;
  localparam logic [DIM_W-1:0]    RST_COLUMN_COUNT = 4'd5;
  localparam logic [LETTER_W-1:0] RST_FILLER      = 8'd90;
  localparam logic [LETTER_W-1:0] RST_ALT_FILLER  = 8'd89;

  // Item operations.
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_PLACE  = 2'd1,
    OP_CIPHER = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_PAIR_SAME = 3'd4
  } status_e;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_DECODE_MODE  = 3'd0,
    REG_ROW_COUNT    = 3'd1,
    REG_COLUMN_COUNT = 3'd2,
    REG_FILLER       = 3'd3,
    REG_ALT_FILLER   = 3'd4
  } reg_idx_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_ADDR,
    S_FINISH
  } state_e;

  // Configuration bundle handed from the register block to the datapath.
  typedef struct packed {
    logic                decode_mode;
    logic [DIM_W-1:0]    row_count;
    logic [DIM_W-1:0]    column_count;
    logic [LETTER_W-1:0] filler_letter;
    logic [LETTER_W-1:0] alternate_filler;
  } cfg_t;

  // Position of a letter in the matrix.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

endpackage

[rtl/pfc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
interface pfc_in_if import pfc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [LETTER_W-1:0] letter_a;
  logic [LETTER_W-1:0] letter_b;

  modport source (output valid, op, letter_a, letter_b, input ready);
  modport sink   (input valid, op, letter_a, letter_b, output ready);
endinterface

interface pfc_out_if import pfc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] out_first;
  logic [LETTER_W-1:0] out_second;
  logic [STATUS_W-1:0] status;

  modport source (output valid, out_first, out_second, status, input ready);
  modport sink   (input valid, out_first, out_second, status, output ready);
endinterface

[rtl/pfc_cfg.sv]
`timescale 1ns / 1ps
// APB-style configuration registers of the Playfair bigram cipher.
module pfc_cfg import pfc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite;

  // Write decode; addresses beyond the register list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_DECODE_MODE:  cfg_d.decode_mode      = pwdata[0];
        REG_ROW_COUNT:    cfg_d.row_count        = pwdata[DIM_W-1:0];
        REG_COLUMN_COUNT: cfg_d.column_count     = pwdata[DIM_W-1:0];
        REG_FILLER:       cfg_d.filler_letter    = pwdata[LETTER_W-1:0];
        REG_ALT_FILLER:   cfg_d.alternate_filler = pwdata[LETTER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (reg_sel)
      REG_DECODE_MODE:  prdata = PDATA_W'(cfg_q.decode_mode);
      REG_ROW_COUNT:    prdata = PDATA_W'(cfg_q.row_count);
      REG_COLUMN_COUNT: prdata = PDATA_W'(cfg_q.column_count);
      REG_FILLER:       prdata = PDATA_W'(cfg_q.filler_letter);
      REG_ALT_FILLER:   prdata = PDATA_W'(cfg_q.alternate_filler);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decode_mode      <= RST_DECODE_MODE;
      cfg_q.row_count        <= RST_ROW_COUNT;
      cfg_q.column_count     <= RST_COLUMN_COUNT;
      cfg_q.filler_letter    <= RST_FILLER;
      cfg_q.alternate_filler <= RST_ALT_FILLER;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/pfc_locate.sv]
`timescale 1ns / 1ps
// Splits two linear cell numbers into row and column for the current width.
module pfc_locate import pfc_pkg::*; #(
  parameter int unsigned IDX_W = 6
) (
  input  logic             clk_i,
  input  logic [IDX_W-1:0] idx_a_i,
  input  logic [IDX_W-1:0] idx_b_i,
  input  logic [DIM_W-1:0] cols_i,
  output pos_t             pos_a_o,
  output pos_t             pos_b_o
);

  pos_t pos_a_q, pos_b_q;

  // Division by a width of 1 to 8: shifts for powers of two, otherwise a
  // multiply by a scaled reciprocal that is exact for values below 64.
  function automatic pos_t split(input logic [ROW_W-1:0] n, input logic [DIM_W-1:0] d);
    logic [12:0]      prod;
    logic [ROW_W-1:0] q;
    logic [ROW_W-1:0] back;
    pos_t             p;
    prod = '0;
    case (d)
      4'd1: q = n;
      4'd2: q = n >> 1;
      4'd3: begin
        prod = 13'(n) * 13'd86;
        q    = ROW_W'(prod >> 8);
      end
      4'd4: q = n >> 2;
      4'd5: begin
        prod = 13'(n) * 13'd52;
        q    = ROW_W'(prod >> 8);
      end
      4'd6: begin
        prod = 13'(n) * 13'd43;
        q    = ROW_W'(prod >> 8);
      end
      4'd7: begin
        prod = 13'(n) * 13'd37;
        q    = ROW_W'(prod >> 8);
      end
      default: q = n >> 3;
    endcase
    back  = ROW_W'(10'(q) * 10'(d));
    p.row = q;
    p.col = COL_W'(n - back);
    return p;
  endfunction

  // Positions are registered so the wrap and address step starts clean.
  always_ff @(posedge clk_i) begin
    pos_a_q <= split(ROW_W'(idx_a_i), cols_i);
    pos_b_q <= split(ROW_W'(idx_b_i), cols_i);
  end

  assign pos_a_o = pos_a_q;
  assign pos_b_o = pos_b_q;

endmodule

[rtl/pfc_cell_store.sv]
`timescale 1ns / 1ps
// Letter matrix store: one write port and two registered read ports.
module pfc_cell_store import pfc_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic [LETTER_W-1:0] wr_data_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_a_i,
  input  logic [AW-1:0]       rd_addr_b_i,
  output logic [LETTER_W-1:0] rd_data_a_o,
  output logic [LETTER_W-1:0] rd_data_b_o
);

  logic [LETTER_W-1:0] mem_q [DEPTH];
  logic [LETTER_W-1:0] rd_a_q, rd_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

[rtl/playfair_bigram_cipher.sv]
`timescale 1ns / 1ps
// Playfair bigram cipher engine: matrix build and bigram encode or decode.
//
// Items arrive on in_ch_i (op, letter_a, letter_b) with a valid/ready
// handshake; every accepted beat yields exactly one result beat on out_ch_o
// (out_first, out_second, status). Clear empties the matrix, place appends
// letter_a unless it is already present or the matrix is full, and cipher transforms
// the pair with the same-row, same-column and rectangle rules. The user must write
// registers over the APB-style port only while the block is idle; the block does not enforce it.
//
// A ciphered bigram reads the letter-to-cell index memory at accept, splits
// the cell number into row and column, reads the letter matrix memory at the
// wrapped cell addresses and registers the result. Clear, place and rejected
// bigrams skip the lookup and go straight to the result register. One item
// is in flight at a time, and the next item is accepted as soon as the result
// sits in the output register, even while the receiver stalls it.
//
// Reset empties the matrix (presence bits and fill count) and loads the
// register defaults; no clearing pass is needed.
module playfair_bigram_cipher import pfc_pkg::*; #(
  parameter int unsigned MAX_CELLS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pfc_in_if.sink             in_ch_i,
  pfc_out_if.source          out_ch_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned CW = $clog2(MAX_CELLS);
  localparam int unsigned FW = $clog2(MAX_CELLS + 1);
  localparam int unsigned LW = 10;

  cfg_t cfg;

  state_e  state_q, state_d;
  logic [FW-1:0] fill_count_q, fill_count_d;
  logic [255:0]  present_q, present_d;
  logic          out_valid_q, out_valid_d;

  logic [CW-1:0] idx_mem_q [256];
  logic [CW-1:0] idx_a_q, idx_b_q;

  status_e             status_q;
  logic                cipher_q;
  logic                hit_a_q, hit_b_q;
  logic [LETTER_W-1:0] out_first_q, out_second_q;
  status_e             out_status_q;

  logic [DIM_W-1:0]    rows_c, cols_c;
  logic [LETTER_W-1:0] a_in, b_in, b_sub;
  logic                pair_same, in_acc;
  logic [7:0]          cap_prod;
  logic                at_cap;
  status_e             acc_status;
  logic                place_ok, cipher_go, clear_go;
  logic                out_free, out_load;

  pos_t          pos_a, pos_b, next_a, next_b;
  logic          same_row, same_col;
  logic [LW-1:0] lin_a, lin_b;
  logic          cell_rd;
  logic [LETTER_W-1:0] cell_a, cell_b;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = 4'd1;
    end else if (v > 4'd8) begin
      r = 4'd8;
    end
    return r;
  endfunction

  // Wrapped target position of one letter of the pair.
  function automatic pos_t shift_pos(input pos_t self, input pos_t other,
                                     input logic srow, input logic scol,
                                     input logic dec, input logic [DIM_W-1:0] rows,
                                     input logic [DIM_W-1:0] cols);
    pos_t res;
    res = self;
    if (srow) begin
      if (dec) begin
        res.col = (self.col != '0) ? self.col - 3'd1 : COL_W'(cols - 4'd1);
      end else begin
        res.col = (({1'b0, self.col} + 4'd1) < cols) ? self.col + 3'd1 : 3'd0;
      end
    end else if (scol) begin
      if (dec) begin
        res.row = (self.row != '0) ? self.row - 6'd1 : ROW_W'(rows - 4'd1);
      end else begin
        res.row = (({1'b0, self.row} + 7'd1) < {3'b000, rows}) ? self.row + 6'd1 : 6'd0;
      end
    end else begin
      res.col = other.col;
    end
    return res;
  endfunction

  pfc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign rows_c = clamp_dim(cfg.row_count);
  assign cols_c = clamp_dim(cfg.column_count);

  // Accept-side decode: filler substitution, presence and capacity checks.
  assign in_acc    = in_ch_i.valid & in_ch_i.ready;
  assign a_in      = in_ch_i.letter_a;
  assign b_in      = in_ch_i.letter_b;
  assign pair_same = (a_in == b_in);
  assign b_sub     = !pair_same ? b_in :
                     (b_in == cfg.filler_letter) ? cfg.alternate_filler : cfg.filler_letter;
  assign cap_prod  = 8'(rows_c) * 8'(cols_c);
  assign at_cap    = (8'(fill_count_q) >= cap_prod) || (fill_count_q >= FW'(MAX_CELLS));

  always_comb begin
    acc_status = ST_OK;
    place_ok   = 1'b0;
    cipher_go  = 1'b0;
    clear_go   = 1'b0;
    unique case (op_e'(in_ch_i.op))
      OP_CLEAR: clear_go = 1'b1;
      OP_PLACE: begin
        if (present_q[a_in]) begin
          acc_status = ST_DUPLICATE;
        end else if (at_cap) begin
          acc_status = ST_FULL;
        end else begin
          place_ok = 1'b1;
        end
      end
      OP_CIPHER: begin
        if (pair_same && cfg.decode_mode) begin
          acc_status = ST_PAIR_SAME;
        end else if (!present_q[a_in] || !present_q[b_sub]) begin
          acc_status = ST_ABSENT;
        end else begin
          cipher_go = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Matrix bookkeeping: fill count and presence bits change at accept.
  always_comb begin
    fill_count_d = fill_count_q;
    present_d    = present_q;
    if (in_acc && clear_go) begin
      fill_count_d = '0;
      present_d    = '0;
    end else if (in_acc && place_ok) begin
      fill_count_d       = fill_count_q + 1'b1;
      present_d[a_in]    = 1'b1;
    end
  end

  // Letter-to-cell index memory, read at accept for both bigram letters.
  // Only one item is in flight, so a write never meets a pending read.
  always_ff @(posedge clk_i) begin
    if (in_acc && place_ok) begin
      idx_mem_q[a_in] <= fill_count_q[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_a_q  <= idx_mem_q[a_in];
      idx_b_q  <= idx_mem_q[b_sub];
      status_q <= acc_status;
      cipher_q <= cipher_go;
    end
  end

  pfc_locate #(
    .IDX_W (CW)
  ) u_locate (
    .clk_i   (clk_i),
    .idx_a_i (idx_a_q),
    .idx_b_i (idx_b_q),
    .cols_i  (cols_c),
    .pos_a_o (pos_a),
    .pos_b_o (pos_b)
  );

  // Playfair rules and linear addresses of the two target cells.
  assign same_row = (pos_a.row == pos_b.row);
  assign same_col = (pos_a.col == pos_b.col);
  assign next_a   = shift_pos(pos_a, pos_b, same_row, same_col, cfg.decode_mode,
                              rows_c, cols_c);
  assign next_b   = shift_pos(pos_b, pos_a, same_row, same_col, cfg.decode_mode,
                              rows_c, cols_c);
  assign lin_a    = LW'(next_a.row) * LW'(cols_c) + LW'(next_a.col);
  assign lin_b    = LW'(next_b.row) * LW'(cols_c) + LW'(next_b.col);
  assign cell_rd  = (state_q == S_ADDR);

  // A cell at or beyond the fill count has not been written since clear.
  always_ff @(posedge clk_i) begin
    if (cell_rd) begin
      hit_a_q <= lin_a < LW'(fill_count_q);
      hit_b_q <= lin_b < LW'(fill_count_q);
    end
  end

  pfc_cell_store #(
    .DEPTH (MAX_CELLS)
  ) u_cell_store (
    .clk_i       (clk_i),
    .wr_en_i     (in_acc && place_ok),
    .wr_addr_i   (fill_count_q[CW-1:0]),
    .wr_data_i   (a_in),
    .rd_en_i     (cell_rd),
    .rd_addr_a_i (lin_a[CW-1:0]),
    .rd_addr_b_i (lin_b[CW-1:0]),
    .rd_data_a_o (cell_a),
    .rd_data_b_o (cell_b)
  );

  // Sequencer: next state, input ready and output register load.
  assign out_free      = !out_valid_q || out_ch_o.ready;
  assign in_ch_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = cipher_go ? S_DIVIDE : S_FINISH;
        end
      end
      S_DIVIDE: state_d = S_ADDR;
      S_ADDR:   state_d = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_count_q <= '0;
      present_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_count_q <= fill_count_d;
      present_q    <= present_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output register holds the result beat until the receiver takes it.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_first_q  <= (cipher_q && hit_a_q) ? cell_a : '0;
      out_second_q <= (cipher_q && hit_b_q) ? cell_b : '0;
      out_status_q <= status_q;
    end
  end

  assign out_ch_o.valid      = out_valid_q;
  assign out_ch_o.out_first  = out_first_q;
  assign out_ch_o.out_second = out_second_q;
  assign out_ch_o.status     = out_status_q;

  // A successful place grows the matrix by exactly one cell.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && place_ok |=> fill_count_q == $past(fill_count_q) + 1'b1)
    else $error("fill count did not advance after a place");

  // The fill count never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_count_q <= FW'(MAX_CELLS))
    else $error("fill count beyond store depth");

  // A ciphered bigram walks the two memory reads in order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cipher_go |=> state_q == S_DIVIDE ##1 state_q == S_ADDR
                            ##1 state_q == S_FINISH)
    else $error("bigram lookup sequence broken");

  // Clear leaves no letter present and an empty matrix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && clear_go |=> present_q == '0 && fill_count_q == '0)
    else $error("clear did not empty the matrix");

endmodule

[tb/playfair_bigram_cipher_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the Playfair bigram cipher engine.
module playfair_bigram_cipher_tb;
  import pfc_pkg::*;

  localparam int unsigned MAX_CELLS   = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASES      = 14;
  localparam int unsigned PHASE_ITEMS = 122;
  localparam int unsigned REPORT_MAX  = 20;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One input beat, with a flag that makes the sender wait for an empty pipe first.
  typedef struct packed {
    logic                drain_first;
    logic [OP_W-1:0]     op;
    logic [LETTER_W-1:0] letter_a;
    logic [LETTER_W-1:0] letter_b;
  } cipher_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] out_first;
    logic [LETTER_W-1:0] out_second;
    logic [STATUS_W-1:0] status;
  } cipher_res_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  pfc_in_if  in_ch ();
  pfc_out_if out_ch ();

  playfair_bigram_cipher #(
    .MAX_CELLS(MAX_CELLS)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register copies and matrix contents as the engine should hold them.
  logic                m_decode;
  logic [DIM_W-1:0]    m_rows;
  logic [DIM_W-1:0]    m_cols;
  logic [LETTER_W-1:0] m_filler;
  logic [LETTER_W-1:0] m_alt;
  logic [LETTER_W-1:0] cell_letters [MAX_CELLS];
  logic [5:0]          letter_cell_index [256];
  logic [255:0]        letter_present;
  int unsigned         fill_count;

  cipher_item_t queued_items [$];
  cipher_res_t  predicted_results [$];
  logic [LETTER_W-1:0] letter_pool [$];

  cipher_item_t taken_item;
  cipher_res_t  got_result;
  cipher_res_t  want_result;

  int unsigned offered_count;
  int unsigned accepted_count;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned config_writes;
  int unsigned cycle_count;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned op_seen [4];
  int unsigned status_seen [8];
  bit          steady_flow;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return v;
  endfunction

  // Letter at a matrix position; cells not filled since the last clear read as zero.
  function automatic logic [LETTER_W-1:0] cell_at(int unsigned r, int unsigned c,
                                                  int unsigned cols);
    int unsigned i;
    i = r * cols + c;
    if (i < fill_count && i < MAX_CELLS) return cell_letters[i];
    return '0;
  endfunction

  // Applies one item to the matrix copy and returns the result the engine owes.
  function automatic cipher_res_t cipher_predict(cipher_item_t it);
    int unsigned rows, cols, cap, ia, ib, ra, ca, rb, cb, na, nb;
    logic [LETTER_W-1:0] a, b;
    cipher_res_t res;
    res  = '0;
    rows = clamp_dim(m_rows);
    cols = clamp_dim(m_cols);
    a    = it.letter_a;
    b    = it.letter_b;
    case (it.op)
      OP_CLEAR: begin
        letter_present = '0;
        fill_count     = 0;
      end
      OP_PLACE: begin
        cap = rows * cols;
        if (cap > MAX_CELLS) cap = MAX_CELLS;
        if (letter_present[a]) begin
          res.status = ST_DUPLICATE;
        end else if (fill_count >= cap) begin
          res.status = ST_FULL;
        end else begin
          cell_letters[fill_count] = a;
          letter_cell_index[a]     = 6'(fill_count);
          letter_present[a]        = 1'b1;
          fill_count++;
        end
      end
      OP_CIPHER: begin
        if (a == b && m_decode) begin
          res.status = ST_PAIR_SAME;
        end else begin
          // A doubled letter is split by the filler before lookup when encoding.
          if (a == b) b = (b == m_filler) ? m_alt : m_filler;
          if (!letter_present[a] || !letter_present[b]) begin
            res.status = ST_ABSENT;
          end else begin
            ia = letter_cell_index[a];
            ib = letter_cell_index[b];
            ra = ia / cols;
            ca = ia % cols;
            rb = ib / cols;
            cb = ib % cols;
            if (ra == rb) begin
              if (m_decode) begin
                na = (ca > 0) ? ca - 1 : cols - 1;
                nb = (cb > 0) ? cb - 1 : cols - 1;
              end else begin
                na = (ca + 1 < cols) ? ca + 1 : 0;
                nb = (cb + 1 < cols) ? cb + 1 : 0;
              end
              res.out_first  = cell_at(ra, na, cols);
              res.out_second = cell_at(rb, nb, cols);
            end else if (ca == cb) begin
              if (m_decode) begin
                na = (ra > 0) ? ra - 1 : rows - 1;
                nb = (rb > 0) ? rb - 1 : rows - 1;
              end else begin
                na = (ra + 1 < rows) ? ra + 1 : 0;
                nb = (rb + 1 < rows) ? rb + 1 : 0;
              end
              res.out_first  = cell_at(na, ca, cols);
              res.out_second = cell_at(nb, cb, cols);
            end else begin
              res.out_first  = cell_at(ra, cb, cols);
              res.out_second = cell_at(rb, ca, cols);
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly no pause, sometimes a few cycles, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [LETTER_W-1:0] pool_letter();
    if (letter_pool.size() == 0) return LETTER_W'($urandom_range(0, 255));
    return letter_pool[$urandom_range(0, letter_pool.size() - 1)];
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("MISMATCH %s on result %0d: got %0d, expected %0d",
               what, results_checked, got, want);
  endtask

  task automatic push_item(logic [OP_W-1:0] op, logic [LETTER_W-1:0] a,
                           logic [LETTER_W-1:0] b, logic drain);
    cipher_item_t it;
    it.drain_first = drain;
    it.op          = op;
    it.letter_a    = a;
    it.letter_b    = b;
    queued_items.insert(queued_items.size(), it);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  task automatic apb_write(reg_idx_e idx, logic [LETTER_W-1:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = PDATA_W'(val);
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_DECODE_MODE:  m_decode = val[0];
      REG_ROW_COUNT:    m_rows   = val[DIM_W-1:0];
      REG_COLUMN_COUNT: m_cols   = val[DIM_W-1:0];
      REG_FILLER:       m_filler = val;
      REG_ALT_FILLER:   m_alt    = val;
      default: ;
    endcase
    config_writes++;
  endtask

  task automatic set_config(logic dm, logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols,
                            logic [LETTER_W-1:0] fil, logic [LETTER_W-1:0] alt);
    apb_write(REG_DECODE_MODE, LETTER_W'(dm));
    apb_write(REG_ROW_COUNT, LETTER_W'(rows));
    apb_write(REG_COLUMN_COUNT, LETTER_W'(cols));
    apb_write(REG_FILLER, fil);
    apb_write(REG_ALT_FILLER, alt);
  endtask

  // Waits for every queued beat to be taken and answered, then lets the pipe settle.
  task automatic wait_idle();
    while (queued_items.size() != 0 || offered_count != accepted_count ||
           predicted_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One random phase: usually a fresh matrix of key and alphabet, then mostly bigrams.
  task automatic build_phase(int unsigned p);
    int unsigned cap, n_alpha, base, stride, k, count, r;
    logic [LETTER_W-1:0] a, b;
    count = 0;
    cap = clamp_dim(m_rows) * clamp_dim(m_cols);
    if (p == 0 || $urandom_range(0, 3) != 0) begin
      push_item(OP_CLEAR, LETTER_W'($urandom_range(0, 255)),
                LETTER_W'($urandom_range(0, 255)), p == 1);
      letter_pool.delete();
      count++;
      k = $urandom_range(0, 6);
      repeat (k) begin
        a = ($urandom_range(0, 9) < 3) ? m_filler : LETTER_W'($urandom_range(0, 255));
        push_item(OP_PLACE, a, LETTER_W'($urandom_range(0, 255)), 1'b0);
        letter_pool.insert(letter_pool.size(), a);
        count++;
      end
      if ($urandom_range(0, 1) != 0) begin
        push_item(OP_PLACE, m_filler, 8'd0, 1'b0);
        push_item(OP_PLACE, m_alt, 8'd255, 1'b0);
        letter_pool.insert(letter_pool.size(), m_filler);
        letter_pool.insert(letter_pool.size(), m_alt);
        count += 2;
      end
      // The alphabet: distinct letters from an odd stride, partial or overfilling.
      n_alpha = ($urandom_range(0, 2) == 0) ? cap / 2 : cap + 2;
      base    = $urandom_range(0, 255);
      stride  = $urandom_range(0, 127) * 2 + 1;
      for (int unsigned j = 0; j < n_alpha; j++) begin
        a = LETTER_W'(base + j * stride);
        push_item(OP_PLACE, a, LETTER_W'($urandom_range(0, 255)), 1'b0);
        letter_pool.insert(letter_pool.size(), a);
        count++;
      end
    end
    while (count < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      a = pool_letter();
      b = pool_letter();
      if (r < 65) begin
        push_item(OP_CIPHER, a, b, 1'b0);
      end else if (r < 75) begin
        push_item(OP_CIPHER, a, a, 1'b0);
      end else if (r < 80) begin
        b = ($urandom_range(0, 1) != 0) ? m_filler : m_alt;
        push_item(OP_CIPHER, b, b, 1'b0);
      end else if (r < 88) begin
        b = LETTER_W'($urandom_range(0, 255));
        if ($urandom_range(0, 1) != 0) push_item(OP_CIPHER, a, b, 1'b0);
        else push_item(OP_CIPHER, b, a, 1'b0);
      end else if (r < 93) begin
        if ($urandom_range(0, 1) != 0) a = LETTER_W'($urandom_range(0, 255));
        push_item(OP_PLACE, a, b, 1'b0);
      end else if (r < 96) begin
        push_item(OP_UNUSED, LETTER_W'($urandom_range(0, 255)),
                  LETTER_W'($urandom_range(0, 255)), 1'b0);
      end else if (r < 97) begin
        push_item(OP_W'($urandom_range(0, 3)), LETTER_W'($urandom_range(0, 255)),
                  LETTER_W'($urandom_range(0, 255)), 1'b0);
      end else begin
        push_item(OP_CIPHER, LETTER_W'($urandom_range(0, 255)),
                  LETTER_W'($urandom_range(0, 255)), $urandom_range(0, 1) != 0);
      end
      count++;
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sender: presents the next queued beat at the falling edge after a random gap.
  always @(negedge clk_i) begin
    if (offered_count == accepted_count) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid = 1'b0;
      end else if (queued_items.size() > 0 &&
                   !(queued_items[0].drain_first && predicted_results.size() != 0)) begin
        in_ch.op       = queued_items[0].op;
        in_ch.letter_a = queued_items[0].letter_a;
        in_ch.letter_b = queued_items[0].letter_b;
        in_ch.valid    = 1'b1;
        offered_count++;
        send_gap = steady_flow ? 0 : pick_gap();
      end else begin
        in_ch.valid = 1'b0;
      end
    end
  end

  // Input beat taken: update the matrix copy and queue the owed result.
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      taken_item = queued_items.pop_front();
      predicted_results.insert(predicted_results.size(), cipher_predict(taken_item));
      op_seen[taken_item.op]++;
      accepted_count++;
    end
  end

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk_i) begin
    if (steady_flow) begin
      out_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  // Result beat: compare every field with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_checked++;
      got_result.out_first  = out_ch.out_first;
      got_result.out_second = out_ch.out_second;
      got_result.status     = out_ch.status;
      if (predicted_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", 32'(got_result), 0);
      end else begin
        want_result = predicted_results.pop_front();
        status_seen[want_result.status]++;
        if (got_result.out_first !== want_result.out_first)
          report_mismatch("out_first", 32'(got_result.out_first),
                          32'(want_result.out_first));
        if (got_result.out_second !== want_result.out_second)
          report_mismatch("out_second", 32'(got_result.out_second),
                          32'(want_result.out_second));
        if (got_result.status !== want_result.status)
          report_mismatch("status", 32'(got_result.status), 32'(want_result.status));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles with %0d results outstanding.",
               cycle_count, predicted_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [DIM_W-1:0]    rows_v, cols_v;
    logic [LETTER_W-1:0] fil_v, alt_v;
    logic                dm_v;
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_CLEAR;
    in_ch.letter_a = '0;
    in_ch.letter_b = '0;
    out_ch.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    steady_flow    = 1'b0;
    m_decode       = RST_DECODE_MODE;
    m_rows         = RST_ROW_COUNT;
    m_cols         = RST_COLUMN_COUNT;
    m_filler       = RST_FILLER;
    m_alt          = RST_ALT_FILLER;
    letter_present = '0;
    fill_count     = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: unused op on the reset settings, then a 2 by 3 matrix.
    push_item(OP_UNUSED, 8'd255, 8'd255, 1'b0);
    wait_idle();
    set_config(1'b0, 4'd2, 4'd3, 8'd90, 8'd89);
    push_item(OP_CLEAR, 8'd0, 8'd0, 1'b0);
    push_item(OP_PLACE, 8'd0, 8'd0, 1'b0);
    push_item(OP_PLACE, 8'd255, 8'd0, 1'b0);
    push_item(OP_PLACE, 8'd0, 8'd255, 1'b0);
    push_item(OP_PLACE, 8'd90, 8'd0, 1'b0);
    push_item(OP_PLACE, 8'd89, 8'd0, 1'b0);
    push_item(OP_PLACE, 8'd65, 8'd0, 1'b0);
    push_item(OP_PLACE, 8'd66, 8'd0, 1'b0);
    // The matrix is full now; a duplicate still reports as a duplicate.
    push_item(OP_PLACE, 8'd67, 8'd0, 1'b0);
    push_item(OP_PLACE, 8'd255, 8'd0, 1'b0);
    // Same row with wraparound, same column, rectangle, doubled letters, absent letters.
    push_item(OP_CIPHER, 8'd0, 8'd255, 1'b1);
    push_item(OP_CIPHER, 8'd90, 8'd0, 1'b0);
    push_item(OP_CIPHER, 8'd0, 8'd89, 1'b0);
    push_item(OP_CIPHER, 8'd255, 8'd66, 1'b0);
    push_item(OP_CIPHER, 8'd65, 8'd65, 1'b0);
    push_item(OP_CIPHER, 8'd90, 8'd90, 1'b0);
    push_item(OP_CIPHER, 8'd0, 8'd7, 1'b0);
    push_item(OP_CIPHER, 8'd7, 8'd0, 1'b0);
    wait_idle();
    apb_write(REG_DECODE_MODE, 8'd1);
    push_item(OP_CIPHER, 8'd255, 8'd90, 1'b0);
    push_item(OP_CIPHER, 8'd89, 8'd89, 1'b0);
    push_item(OP_CIPHER, 8'd89, 8'd0, 1'b0);
    wait_idle();
    // A filler pair equal to the doubled letter keeps the pair identical.
    set_config(1'b0, 4'd2, 4'd3, 8'd65, 8'd65);
    push_item(OP_CIPHER, 8'd65, 8'd65, 1'b0);
    wait_idle();
    // Growing the matrix without a clear leaves the bottom row empty.
    set_config(1'b0, 4'd3, 4'd3, 8'd90, 8'd89);
    push_item(OP_CIPHER, 8'd0, 8'd89, 1'b0);
    wait_idle();

    // Random phases, the early ones on the extreme dimensions and fillers.
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: begin rows_v = 4'd1;  cols_v = 4'd8;  end
        1: begin rows_v = 4'd8;  cols_v = 4'd1;  end
        2: begin rows_v = 4'd8;  cols_v = 4'd8;  end
        3: begin rows_v = 4'd0;  cols_v = 4'd15; end
        4: begin rows_v = 4'd15; cols_v = 4'd0;  end
        5: begin rows_v = 4'd1;  cols_v = 4'd1;  end
        default: begin
          rows_v = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 15))
                                               : DIM_W'($urandom_range(1, 8));
          cols_v = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 15))
                                               : DIM_W'($urandom_range(1, 8));
        end
      endcase
      dm_v  = (p < 6) ? p[0] : 1'($urandom_range(0, 1));
      fil_v = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : LETTER_W'($urandom_range(0, 255));
      case (p)
        2: alt_v = fil_v;
        3: alt_v = 8'd255;
        4: alt_v = 8'd0;
        default: alt_v = ($urandom_range(0, 99) < 15) ? fil_v
                                                      : LETTER_W'($urandom_range(0, 255));
      endcase
      set_config(dm_v, rows_v, cols_v, fil_v, alt_v);
      steady_flow = (p % 5 == 3);
      build_phase(p);
      wait_idle();
    end
    steady_flow = 1'b0;
    wait_idle();

    $display("Ran %0d items (%0d clear, %0d place, %0d cipher, %0d unused op)",
             accepted_count, op_seen[OP_CLEAR], op_seen[OP_PLACE], op_seen[OP_CIPHER],
             op_seen[OP_UNUSED]);
    $display("under %0d register writes; checked %0d results: %0d ok, %0d duplicate,",
             config_writes, results_checked, status_seen[ST_OK],
             status_seen[ST_DUPLICATE]);
    $display("%0d full, %0d absent, %0d identical pair; %0d mismatches.",
             status_seen[ST_FULL], status_seen[ST_ABSENT], status_seen[ST_PAIR_SAME],
             mismatch_count);
    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
